// ===== rtl/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants for the sample voice mixer.
// Holds the action codes, the controller states and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package svm_pkg;
	localparam int unsigned VOICES = 8;
	localparam int unsigned VOICE_W = 3;
	localparam int unsigned SAMPLE_BYTES = 16384;
	localparam int unsigned ADDR_W = 14;
	localparam int unsigned POS_W = 23;

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_START = 3'd1,
		ACT_STOP  = 3'd2,
		ACT_STOP_ALL = 3'd3,
		ACT_WRITE = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_MIX,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear_frame;
		logic do_simple;
		logic do_start;
		logic rd_issue;
		logic mix;
		logic [VOICE_W-1:0] vsel;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [VOICE_W-1:0] free_index;
		logic any_free;
	} status_t;
endpackage
`default_nettype wire

// ===== rtl/svm_datapath.sv =====
// ----------------------------------------------------------------------------
// svm_datapath: voice registers, sample memory and the stereo accumulator.
// One voice is processed per visit of the read/mix steps.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire svm_pkg::cmd_t cmd,
	output svm_pkg::status_t status,
	input  wire logic [2:0] action,
	input  wire logic [2:0] voice,
	input  wire logic [13:0] address,
	input  wire logic signed [7:0] sample_byte,
	input  wire logic [14:0] length,
	input  wire logic [15:0] speed,
	input  wire logic signed [14:0] loop_start,
	input  wire logic [7:0] level_left,
	input  wire logic [7:0] level_right,
	output logic [7:0] left_sample,
	output logic [7:0] right_sample,
	output logic started,
	output logic [2:0] voice_index,
	output logic done
);
	localparam int unsigned NV = svm_pkg::VOICES;

	logic [13:0] base_q [NV];
	logic [14:0] end_q [NV];
	logic [22:0] pos_q [NV];
	logic signed [14:0] loop_q [NV];
	logic [15:0] step_q [NV];
	logic [7:0] gl_q [NV];
	logic [7:0] gr_q [NV];
	logic [7:0] mem [svm_pkg::SAMPLE_BYTES];
	logic [7:0] rd_q;
	logic [7:0] l_q, r_q;

	logic [NV-1:0] free_vec;
	always_comb begin
		status.any_free = 1'b0;
		status.free_index = '0;
		for (int i = NV - 1; i >= 0; i--) begin
			free_vec[i] = (gl_q[i] == 8'd0) && (gr_q[i] == 8'd0);
			if (free_vec[i]) begin
				status.any_free = 1'b1;
				status.free_index = svm_pkg::VOICE_W'(i);
			end
		end
	end

	// Per-voice combinational terms for the selected voice.
	logic [22:0] limit;
	logic playing;
	logic [13:0] rd_addr;
	logic [22:0] pos_next;
	always_comb begin
		limit = {end_q[cmd.vsel], 8'd0};
		playing = (pos_q[cmd.vsel] < limit);
		rd_addr = base_q[cmd.vsel] + pos_q[cmd.vsel][21:8];
		pos_next = pos_q[cmd.vsel] + 23'(step_q[cmd.vsel]);
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue)
			rd_q <= mem[rd_addr];
		if (cmd.do_simple && action == svm_pkg::ACT_WRITE)
			mem[address] <= sample_byte;
	end

	// (s * g) >> 8 rounded toward -inf as arithmetic shift of product.
	function automatic logic [7:0] scale(input logic [7:0] raw, input logic [7:0] g);
		logic signed [16:0] p;
		begin
			p = $signed({{9{raw[7]}}, raw}) * $signed({9'd0, g});
			scale = p[15:8];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) begin
				base_q[i] <= '0; end_q[i] <= '0; pos_q[i] <= '0; loop_q[i] <= '0;
				step_q[i] <= '0; gl_q[i] <= '0; gr_q[i] <= '0;
			end
			l_q <= 8'd128; r_q <= 8'd128; started <= 1'b0; voice_index <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
			if (cmd.clear_frame) begin
				l_q <= 8'd128; r_q <= 8'd128; started <= 1'b0; voice_index <= '0;
			end
			if (cmd.do_simple) begin
				unique case (action)
					svm_pkg::ACT_STOP: begin
						gl_q[voice] <= '0; gr_q[voice] <= '0;
					end
					svm_pkg::ACT_STOP_ALL: begin
						for (int i = 0; i < NV; i++) begin
							gl_q[i] <= '0; gr_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.do_start && status.any_free) begin
				base_q[status.free_index] <= address;
				end_q[status.free_index] <= length;
				pos_q[status.free_index] <= '0;
				loop_q[status.free_index] <= loop_start;
				step_q[status.free_index] <= speed;
				gl_q[status.free_index] <= level_left;
				gr_q[status.free_index] <= level_right;
				started <= 1'b1;
				voice_index <= status.free_index;
			end
			if (cmd.mix && !free_vec[cmd.vsel]) begin
				logic [22:0] p;
				p = pos_q[cmd.vsel];
				if (playing) begin
					l_q <= l_q + scale(rd_q, gl_q[cmd.vsel]);
					r_q <= r_q + scale(rd_q, gr_q[cmd.vsel]);
					p = pos_next;
				end
				if (p >= limit) begin
					if (loop_q[cmd.vsel] < 0) begin
						gl_q[cmd.vsel] <= '0; gr_q[cmd.vsel] <= '0;
					end else begin
						p = {1'b0, loop_q[cmd.vsel][13:0], 8'd0};
					end
				end
				pos_q[cmd.vsel] <= p;
			end
		end
	end

	assign left_sample = l_q;
	assign right_sample = r_q;
endmodule
`default_nettype wire

// ===== rtl/svm_ctrl.sv =====
// ----------------------------------------------------------------------------
// svm_ctrl: sequencer that walks voices on a tick and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [2:0] action,
	output logic busy,
	output svm_pkg::cmd_t cmd
);
	svm_pkg::state_t state_q, state_next;
	logic [svm_pkg::VOICE_W-1:0] v_q;
	logic last;

	assign last = (v_q == svm_pkg::VOICE_W'(svm_pkg::VOICES - 1));

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			svm_pkg::ST_IDLE:
				if (start)
					state_next = (action == svm_pkg::ACT_TICK) ? svm_pkg::ST_READ
						: svm_pkg::ST_DONE;
			svm_pkg::ST_READ: state_next = svm_pkg::ST_MIX;
			svm_pkg::ST_WAIT: state_next = svm_pkg::ST_MIX;
			svm_pkg::ST_MIX: state_next = last ? svm_pkg::ST_DONE : svm_pkg::ST_READ;
			svm_pkg::ST_DONE: state_next = svm_pkg::ST_IDLE;
			default: state_next = svm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.vsel = v_q;
		busy = (state_q != svm_pkg::ST_IDLE);
		unique case (state_q)
			svm_pkg::ST_IDLE: begin
				cmd.clear_frame = start;
				cmd.do_simple = start;
				cmd.do_start = start && (action == svm_pkg::ACT_START);
			end
			svm_pkg::ST_READ: cmd.rd_issue = 1'b1;
			svm_pkg::ST_MIX: cmd.mix = 1'b1;
			svm_pkg::ST_DONE: cmd.emit = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svm_pkg::ST_IDLE;
			v_q <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == svm_pkg::ST_IDLE)
				v_q <= '0;
			else if (state_q == svm_pkg::ST_MIX)
				v_q <= v_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/sample_voice_mixer_core.sv =====
// ----------------------------------------------------------------------------
// sample_voice_mixer_core: eight-voice signed 8-bit sample player and mixer.
// Channel     | handshake            | payload
// command     | start / busy         | action voice address sample_byte length
//             |                      | speed loop_start level_left level_right
// result      | done (one cycle)     | left_sample right_sample started voice_index
// A tick walks all the voices in turn, with one memory read step and one mix
// step per voice, since all voices share the single sample memory port.
// Other actions skip the voice walk. Reset clears all voices to free; the
// sample memory is not cleared. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sample_voice_mixer_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic [2:0] action,
	input  wire logic [2:0] voice,
	input  wire logic [13:0] address,
	input  wire logic signed [7:0] sample_byte,
	input  wire logic [14:0] length,
	input  wire logic [15:0] speed,
	input  wire logic signed [14:0] loop_start,
	input  wire logic [7:0] level_left,
	input  wire logic [7:0] level_right,
	output logic done,
	output logic [7:0] left_sample,
	output logic [7:0] right_sample,
	output logic started,
	output logic [2:0] voice_index
);
	svm_pkg::cmd_t cmd;
	svm_pkg::status_t status;

	// The datapath samples the command fields only in the accept cycle, so the
	// sender is free to change them once busy is high.
	svm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .action(action),
		.busy(busy), .cmd(cmd)
	);

	svm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.action(action), .voice(voice), .address(address),
		.sample_byte(sample_byte), .length(length), .speed(speed),
		.loop_start(loop_start), .level_left(level_left), .level_right(level_right),
		.left_sample(left_sample), .right_sample(right_sample),
		.started(started), .voice_index(voice_index), .done(done)
	);
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sample_voice_mixer_core.
// Fills a window of the sample memory, runs directed voice cases and a long
// random mix of ticks, starts, stops and writes. A local model of the voices
// predicts each frame and start status, and a monitor compares every done
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	// Action codes that the block leaves undefined; they must change no voice.
	localparam logic [2:0] ACT_RSVD_5 = 3'd5;
	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;
	localparam int IDLE_LIMIT = 4000;
	// Written window of the sample memory; it wraps past the top address.
	localparam int WIN_BASE = 'h3fc0;
	localparam int WIN_BYTES = 128;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] action = '0;
	logic [2:0] voice = '0;
	logic [13:0] address = '0;
	logic signed [7:0] sample_byte = '0;
	logic [14:0] length = '0;
	logic [15:0] speed = '0;
	logic signed [14:0] loop_start = '0;
	logic [7:0] level_left = '0;
	logic [7:0] level_right = '0;
	logic done;
	logic [7:0] left_sample;
	logic [7:0] right_sample;
	logic started;
	logic [2:0] voice_index;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] right;
		logic started;
		logic [2:0] index;
	} frame_t;

	// Mirror of the voice registers and the sample memory.
	logic [13:0] m_base [svm_pkg::VOICES];
	logic [14:0] m_end [svm_pkg::VOICES];
	logic [22:0] m_pos [svm_pkg::VOICES];
	logic signed [14:0] m_loop [svm_pkg::VOICES];
	logic [15:0] m_step [svm_pkg::VOICES];
	logic [7:0] m_gain_l [svm_pkg::VOICES];
	logic [7:0] m_gain_r [svm_pkg::VOICES];
	logic [7:0] m_mem [svm_pkg::SAMPLE_BYTES];

	frame_t pending_frames[$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	int ticks_sent = 0;
	int starts_ok = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	sample_voice_mixer_core dut (.*);

	always #10 clk = ~clk;

	// Signed byte times an unsigned gain, then an arithmetic shift right by 8.
	function automatic logic [7:0] scale_byte(logic [7:0] raw, logic [7:0] gain);
		int p;
		p = $signed(raw) * $signed({1'b0, gain});
		return 8'(p >>> 8);
	endfunction

	// Apply one accepted transaction to the mirror and return the expected result.
	function automatic frame_t mix_and_update(logic [2:0] act, logic [2:0] vc,
			logic [13:0] addr, logic [7:0] sb, logic [14:0] len, logic [15:0] spd,
			logic signed [14:0] lp, logic [7:0] vl, logic [7:0] vr);
		frame_t f;
		logic [22:0] limit;
		logic [7:0] raw;
		f = '{left: 8'd128, right: 8'd128, started: 1'b0, index: 3'd0};
		case (act)
			svm_pkg::ACT_TICK: begin
				for (int v = 0; v < svm_pkg::VOICES; v++) begin
					if (m_gain_l[v] == 0 && m_gain_r[v] == 0)
						continue;
					limit = {m_end[v], 8'd0};
					if (m_pos[v] < limit) begin
						raw = m_mem[14'(m_base[v] + m_pos[v][22:8])];
						f.left = f.left + scale_byte(raw, m_gain_l[v]);
						f.right = f.right + scale_byte(raw, m_gain_r[v]);
						m_pos[v] = m_pos[v] + m_step[v];
					end
					if (m_pos[v] >= limit) begin
						if (m_loop[v] < 0) begin
							m_gain_l[v] = '0;
							m_gain_r[v] = '0;
						end else begin
							m_pos[v] = {1'b0, m_loop[v][13:0], 8'd0};
						end
					end
				end
			end
			svm_pkg::ACT_START: begin
				for (int v = 0; v < svm_pkg::VOICES; v++) begin
					if (m_gain_l[v] == 0 && m_gain_r[v] == 0) begin
						m_base[v] = addr;
						m_end[v] = len;
						m_pos[v] = '0;
						m_loop[v] = lp;
						m_step[v] = spd;
						m_gain_l[v] = vl;
						m_gain_r[v] = vr;
						f.started = 1'b1;
						f.index = 3'(v);
						break;
					end
				end
			end
			svm_pkg::ACT_STOP: begin
				m_gain_l[vc] = '0;
				m_gain_r[vc] = '0;
			end
			svm_pkg::ACT_STOP_ALL: begin
				for (int v = 0; v < svm_pkg::VOICES; v++) begin
					m_gain_l[v] = '0;
					m_gain_r[v] = '0;
				end
			end
			svm_pkg::ACT_WRITE: m_mem[addr] = sb;
			default: ;
		endcase
		return f;
	endfunction

	// Drive one command at the falling edge and hold it until it is accepted.
	// start stays high afterwards so a burst can follow without a bubble.
	task automatic send_command(logic [2:0] act, logic [2:0] vc, logic [13:0] addr,
			logic [7:0] sb, logic [14:0] len, logic [15:0] spd,
			logic signed [14:0] lp, logic [7:0] vl, logic [7:0] vr);
		@(negedge clk);
		start <= 1'b1;
		action <= act;
		voice <= vc;
		address <= addr;
		sample_byte <= sb;
		length <= len;
		speed <= spd;
		loop_start <= lp;
		level_left <= vl;
		level_right <= vr;
		do @(posedge clk); while (busy);
		pending_frames.push_back(mix_and_update(act, vc, addr, sb, len, spd, lp, vl, vr));
		sent++;
		if (act == svm_pkg::ACT_TICK)
			ticks_sent++;
	endtask

	task automatic hold_off(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Bursts of random length separated by random gaps, with some long runs.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			hold_off($urandom_range(0, 7));
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic wait_for_drain();
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	task automatic simple_command(logic [2:0] act, logic [2:0] vc);
		send_command(act, vc, 14'($urandom), 8'($urandom), 15'($urandom), 16'($urandom),
			15'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic start_voice(logic [13:0] addr, logic [14:0] len, logic [15:0] spd,
			logic signed [14:0] lp, logic [7:0] vl, logic [7:0] vr);
		send_command(svm_pkg::ACT_START, 3'($urandom), addr, 8'($urandom), len, spd, lp,
			vl, vr);
	endtask

	// Every byte of the window is written first. A voice only reads offsets
	// below its length, so voices placed inside the window never reach an
	// unwritten location.
	task automatic test_memory_fill();
		for (int a = 0; a < WIN_BYTES; a++)
			send_command(svm_pkg::ACT_WRITE, 3'($urandom), 14'(WIN_BASE + a), 8'($urandom),
				15'($urandom), 16'($urandom), 15'($urandom), 8'($urandom), 8'($urandom));
		// Pin the extreme byte values at known places for the directed cases.
		send_command(svm_pkg::ACT_WRITE, '0, 14'd0, 8'h80, '0, '0, '0, '0, '0);
		send_command(svm_pkg::ACT_WRITE, '0, 14'd1, 8'h7f, '0, '0, '0, '0, '0);
		send_command(svm_pkg::ACT_WRITE, '0, 14'h3fff, 8'hff, '0, '0, '0, '0, '0);
	endtask

	task automatic test_directed();
		simple_command(svm_pkg::ACT_TICK, '0);               // silence with no voice
		start_voice(14'd0, 15'd2, 16'd256, -15'sd1, 8'hff, 8'hff);  // full gain, -128
		start_voice(14'd0, 15'd4, 16'd0, -15'sd1, 8'd1, 8'hff);     // zero speed
		start_voice(14'h3ffe, 15'd6, 16'd256, 15'sd1, 8'd77, 8'd0); // address wrap, loop
		start_voice(14'd5, 15'd0, 16'd256, -15'sd1, 8'd9, 8'd9);    // zero length
		start_voice(14'd8, 15'd3, 16'd256, 15'sd3, 8'd0, 8'd50);    // loop at the end
		start_voice(14'd9, 15'd5, 16'hffff, 15'sd0, 8'd40, 8'd40);  // maximum speed
		start_voice(14'd1, 15'd3, 16'd128, 15'sd16383, 8'd5, 8'd0); // loop past the end
		start_voice(14'd2, 15'd2, 16'd256, -15'sd1, 8'd0, 8'd0);    // both gains zero
		repeat (5) simple_command(svm_pkg::ACT_TICK, '0);
		// Three voices are free again here; these starts take all of them.
		repeat (3) start_voice(14'd3, 15'd40, 16'd256, -15'sd1, 8'd3, 8'd3);
		start_voice(14'd3, 15'd40, 16'd256, -15'sd1, 8'd3, 8'd3);   // no free voice
		simple_command(svm_pkg::ACT_STOP, 3'd7);
		simple_command(svm_pkg::ACT_STOP, 3'd2);
		simple_command(ACT_RSVD_5, '0);
		simple_command(ACT_RSVD_6, '0);
		simple_command(ACT_RSVD_7, '0);
		simple_command(svm_pkg::ACT_TICK, '0);
		simple_command(svm_pkg::ACT_STOP_ALL, '0);
		simple_command(svm_pkg::ACT_TICK, '0);
	endtask

	task automatic test_random_mix(int count);
		int pick;
		int off;
		int room;
		logic [14:0] len;
		logic signed [14:0] lp;
		logic [15:0] spd;
		for (int i = 0; i < count; i++) begin
			pace_sender();
			if (i == count / 2) begin
				// Let the block run dry once before carrying on.
				hold_off(1);
				wait_for_drain();
			end
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				simple_command(svm_pkg::ACT_TICK, 3'($urandom));
			end else if (pick < 75) begin
				// Samples stay inside the written window; mostly short ones at
				// sensible speeds, now and then the extremes.
				off = $urandom_range(0, WIN_BYTES - 1);
				room = WIN_BYTES - off;
				len = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, room))
					: 15'($urandom_range(0, (room < 40) ? room : 40));
				spd = ($urandom_range(0, 7) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 600));
				lp = ($urandom_range(0, 2) == 0) ? -15'sd1
					: ($urandom_range(0, 5) == 0) ? 15'($urandom)
					: 15'($urandom_range(0, 45));
				start_voice(14'(WIN_BASE + off), len, spd, lp,
					($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom),
					($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom));
			end else if (pick < 85) begin
				simple_command(svm_pkg::ACT_STOP, 3'($urandom));
			end else if (pick < 88) begin
				simple_command(svm_pkg::ACT_STOP_ALL, 3'($urandom));
			end else if (pick < 97) begin
				simple_command(svm_pkg::ACT_WRITE, 3'($urandom));
			end else begin
				simple_command(3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7)), 3'($urandom));
			end
		end
		hold_off(0);
	endtask

	// Compare every done transaction against the oldest prediction.
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && done) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: result with nothing expected: left %0d right %0d", $time,
					left_sample, right_sample);
				errors++;
			end else begin
				want = pending_frames.pop_front();
				checked++;
				if (left_sample !== want.left) begin
					$display("%0t: left_sample expected %0d actual %0d", $time,
						want.left, left_sample);
					errors++;
				end
				if (right_sample !== want.right) begin
					$display("%0t: right_sample expected %0d actual %0d", $time,
						want.right, right_sample);
					errors++;
				end
				if (started !== want.started) begin
					$display("%0t: started expected %0d actual %0d", $time,
						want.started, started);
					errors++;
				end
				if (voice_index !== want.index) begin
					$display("%0t: voice_index expected %0d actual %0d", $time,
						want.index, voice_index);
					errors++;
				end
				if (want.started)
					starts_ok++;
			end
		end
	end

	// Watchdog: ends the run after too many cycles in which nothing moved.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int v = 0; v < svm_pkg::VOICES; v++) begin
			m_base[v] = '0;
			m_end[v] = '0;
			m_pos[v] = '0;
			m_loop[v] = '0;
			m_step[v] = '0;
			m_gain_l[v] = '0;
			m_gain_r[v] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_memory_fill();
		test_directed();
		test_random_mix(400);
		wait_for_drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d commands (%0d ticks); checked %0d results, %0d voice starts.",
			sent, ticks_sent, checked, starts_ok);
		$display("Covered memory fill, voice start/stop/loop/wrap cases and random mixing.");
		if (errors == 0 && pending_frames.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
